// ===== rtl/core/itrd_pkg.sv =====
// Shared constants, types and helper functions for the radix digit converter.
package itrd_pkg;

  // Input value width and derived widths.
  localparam int unsigned VALUE_WIDTH = 31;
  localparam int unsigned RADIX_W     = 6;
  localparam int unsigned DIGIT_W     = 6;
  localparam int unsigned CHAR_W      = 7;
  localparam int unsigned IDX_W       = $clog2(VALUE_WIDTH);
  localparam int unsigned CNT_W       = $clog2(VALUE_WIDTH + 1);
  localparam int unsigned STEP_W      = $clog2(VALUE_WIDTH);

  // Stream payload widths, padded up to whole bytes.
  localparam int unsigned S_TDATA_W = ((VALUE_WIDTH + 7) / 8) * 8;
  localparam int unsigned M_TDATA_W = ((CHAR_W + 7) / 8) * 8;

  // Configuration port.
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam logic        REG_RADIX  = 1'b0;

  // Radix limits and character codes.
  localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(36);
  localparam logic [DIGIT_W-1:0] DEC_LIMIT = DIGIT_W'(10);
  localparam logic [CHAR_W-1:0]  CHAR_ZERO = CHAR_W'(48);
  localparam logic [CHAR_W-1:0]  CHAR_A    = CHAR_W'(65);

  // Sequencer states of the top level.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } state_e;

  // Request to the shared divider.
  typedef struct packed {
    logic                   start;
    logic [VALUE_WIDTH-1:0] dividend;
    logic [RADIX_W-1:0]     divisor;
  } div_req_t;

  // Response from the shared divider, valid while done is high.
  typedef struct packed {
    logic                   done;
    logic [VALUE_WIDTH-1:0] quotient;
    logic [DIGIT_W-1:0]     remainder;
  } div_rsp_t;

  // Saturate the radix register into the supported range.
  function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] res;
    if (r < RADIX_MIN) begin
      res = RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      res = RADIX_MAX;
    end else begin
      res = r;
    end
    return res;
  endfunction

  // Map a digit value to its ASCII character.
  function automatic logic [CHAR_W-1:0] to_ascii(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] res;
    if (d < DEC_LIMIT) begin
      res = CHAR_ZERO + CHAR_W'(d);
    end else begin
      res = CHAR_A + CHAR_W'(d - DEC_LIMIT);
    end
    return res;
  endfunction

endpackage

// ===== rtl/core/itrd_divider.sv =====
// Bit-serial restoring divider: one quotient bit per cycle over the value width.
module itrd_divider
  import itrd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  logic [STEP_W-1:0]      step_q, step_d;
  logic [VALUE_WIDTH-1:0] quot_q, quot_d;
  logic [DIGIT_W-1:0]     rem_q, rem_d;
  logic [RADIX_W-1:0]     div_q, div_d;

  logic [DIGIT_W:0] trial;
  logic [DIGIT_W:0] diff;
  logic             fits;

  // One restoring step: shift in the next dividend bit and try to subtract.
  always_comb begin
    trial = {rem_q, quot_q[VALUE_WIDTH-1]};
    diff  = trial - {1'b0, div_q};
    fits  = (trial >= {1'b0, div_q});
  end

  // Step control and datapath update.
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      step_d = '0;
      quot_d = req_i.dividend;
      rem_d  = '0;
      div_d  = req_i.divisor;
    end else if (busy_q) begin
      quot_d = {quot_q[VALUE_WIDTH-2:0], fits};
      rem_d  = fits ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
      step_d = step_q + STEP_W'(1);
      if (step_q == STEP_W'(VALUE_WIDTH - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    div_q  <= div_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quot_q;
  assign rsp_o.remainder = rem_q;

endmodule

// ===== rtl/core/integer_to_radix_digits.sv =====
// Top level: converts an integer to ASCII digits in a programmable radix.
// Each digit costs one pass of the shared serial divider, so an input with D digits (1 to 31)
// takes D divider passes; the digits are then emitted most significant first, one per cycle
// while the output is not stalled. A new value is taken only in idle, once the last digit of
// the previous one has been loaded into the output register.
// Reset is asynchronous and active low: the radix returns to 2 and the sequencer idles.
module integer_to_radix_digits
  import itrd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Input stream.
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [S_TDATA_W-1:0]  s_tdata,   // [30:0] value, [31] zero
  // Output stream.
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [M_TDATA_W-1:0]  m_tdata,   // [6:0] digit_char, [7] zero
  output logic                  m_tlast,   // last_digit
  // Configuration port.
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  state_e state_q, state_d;

  logic [RADIX_W-1:0] radix_q;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [IDX_W-1:0]   pos_q, pos_d;
  logic [DIGIT_W-1:0] store_q [VALUE_WIDTH];

  logic              m_tvalid_q, m_tvalid_d;
  logic [CHAR_W-1:0] char_q;
  logic              last_q;

  logic     in_accept;
  logic     store_we;
  logic     final_digit;
  logic     load;
  div_req_t div_req;
  div_rsp_t div_rsp;

  // Configuration register access.
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= RADIX_MIN;
    end else if (psel && penable && pwrite && (paddr[2] == REG_RADIX)) begin
      radix_q <= pwdata[RADIX_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_RADIX) begin
      prdata[RADIX_W-1:0] = radix_q;
    end
  end

  // Shared divider.
  itrd_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_rsp.done && (div_rsp.quotient == '0)) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (load && (pos_q == '0)) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    s_tready         = 1'b0;
    store_we         = 1'b0;
    load             = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = div_rsp.quotient;
    div_req.divisor  = clamp_radix(radix_q);
    unique case (state_q)
      ST_IDLE: begin
        s_tready         = 1'b1;
        div_req.start    = s_tvalid;
        div_req.dividend = s_tdata[VALUE_WIDTH-1:0];
      end
      ST_DIV: begin
        store_we      = div_rsp.done;
        div_req.start = div_rsp.done && (div_rsp.quotient != '0);
      end
      ST_EMIT: begin
        load = !m_tvalid_q || m_tready;
      end
      default: ;
    endcase
  end

  assign in_accept   = s_tvalid && s_tready;
  assign final_digit = store_we && (div_rsp.quotient == '0);

  // Digit count and emission position.
  always_comb begin
    count_d = count_q;
    pos_d   = pos_q;
    if (in_accept) begin
      count_d = '0;
    end else if (store_we) begin
      count_d = count_q + CNT_W'(1);
    end
    if (final_digit) begin
      pos_d = count_q[IDX_W-1:0];
    end else if (load) begin
      pos_d = pos_q - IDX_W'(1);
    end
  end

  // Output register handshake.
  always_comb begin
    m_tvalid_d = m_tvalid_q;
    if (load) begin
      m_tvalid_d = 1'b1;
    end else if (m_tready) begin
      m_tvalid_d = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      count_q    <= '0;
      pos_q      <= '0;
      m_tvalid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      pos_q      <= pos_d;
      m_tvalid_q <= m_tvalid_d;
    end
  end

  // Digit store, written least significant first.
  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_q[count_q[IDX_W-1:0]] <= div_rsp.remainder;
    end
  end

  // Output payload, most significant digit first.
  always_ff @(posedge clk_i) begin
    if (load) begin
      char_q <= to_ascii(store_q[pos_q]);
      last_q <= (pos_q == '0);
    end
  end

  assign m_tvalid = m_tvalid_q;
  assign m_tdata  = {{(M_TDATA_W - CHAR_W){1'b0}}, char_q};
  assign m_tlast  = last_q;

endmodule
